### hw/rtl/npfd_pkg.sv
// Shared types, constants and codes for the now-playing frame decoder.
`timescale 1ns / 1ps

package npfd_pkg;

    localparam logic [8:0] HEADER_LEN   = 9'd12;
    localparam logic [8:0] COUNT_SAT    = 9'd511;
    localparam logic [7:0] FLAG_MAX     = 8'd7;
    localparam logic [7:0] MAX_TEXT_LEN = 8'd144;

    // Byte positions within the header
    localparam logic [8:0] POS_FLAGS    = 9'd0;
    localparam logic [8:0] POS_TITLE    = 9'd1;
    localparam logic [8:0] POS_ARTIST   = 9'd2;
    localparam logic [8:0] POS_ALBUM    = 9'd3;
    localparam logic [8:0] POS_ELAPSED  = 9'd4;
    localparam logic [8:0] POS_DURATION = 9'd8;

    // Segment codes
    localparam logic [2:0] SEG_HEADER = 3'd0;
    localparam logic [2:0] SEG_TITLE  = 3'd1;
    localparam logic [2:0] SEG_ARTIST = 3'd2;
    localparam logic [2:0] SEG_ALBUM  = 3'd3;
    localparam logic [2:0] SEG_EXCESS = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_FLAGS  = 3'd2;
    localparam logic [2:0] ST_LEN_LIMIT  = 3'd3;
    localparam logic [2:0] ST_SIZE       = 3'd4;
    localparam logic [2:0] ST_ZERO_TEXT  = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  segment;
        logic [7:0]  text_char;
        logic [7:0]  text_offset;
        logic        frame_done;
        logic [2:0]  status;
        logic        connected;
        logic        ready_res;
        logic        playing;
        logic [31:0] elapsed_seconds;
        logic [31:0] duration_seconds;
    } t_out_item;

    // Replace one byte lane of a little-endian word
    function automatic logic [31:0] put_lane(input logic [31:0] word,
                                             input logic [1:0]  lane,
                                             input logic [7:0]  value);
        logic [31:0] w;
        w = word;
        w[lane*8 +: 8] = value;
        return w;
    endfunction

endpackage

### hw/rtl/npfd_parse.sv
// Frame parser: header capture, text tagging and end-of-frame checks.
`timescale 1ns / 1ps

module npfd_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  npfd_pkg::t_in_item   i_item,
    output npfd_pkg::t_out_item  o_result
);

    logic [8:0]  r_byte_count;
    logic [7:0]  r_flag_byte;
    logic [7:0]  r_title_length;
    logic [7:0]  r_artist_length;
    logic [7:0]  r_album_length;
    logic [31:0] r_elapsed_accum;
    logic [31:0] r_duration_accum;
    logic        r_zero_seen;

    logic [8:0]  n_byte_count;
    logic [7:0]  n_flag_byte;
    logic [7:0]  n_title_length;
    logic [7:0]  n_artist_length;
    logic [7:0]  n_album_length;
    logic [31:0] n_elapsed_accum;
    logic [31:0] n_duration_accum;
    logic        n_zero_seen;

    logic        in_header;
    logic        sat;
    logic [9:0]  q;
    logic [9:0]  e1;
    logic [9:0]  e2;
    logic [9:0]  e3;
    logic [9:0]  frame_size;
    logic [9:0]  expect_size;
    logic [2:0]  st;

    assign in_header = r_byte_count < npfd_pkg::HEADER_LEN;
    assign sat       = r_byte_count >= npfd_pkg::COUNT_SAT;
    assign q         = {1'b0, r_byte_count - npfd_pkg::HEADER_LEN};
    assign e1        = {2'b00, r_title_length};
    assign e2        = e1 + {2'b00, r_artist_length};
    assign e3        = e2 + {2'b00, r_album_length};

    // Header capture, zero-byte tracking after the header and count advance for this byte
    always_comb begin
        n_flag_byte      = r_flag_byte;
        n_title_length   = r_title_length;
        n_artist_length  = r_artist_length;
        n_album_length   = r_album_length;
        n_elapsed_accum  = r_elapsed_accum;
        n_duration_accum = r_duration_accum;
        n_zero_seen      = r_zero_seen;
        if (in_header) begin
            if (r_byte_count == npfd_pkg::POS_FLAGS) begin
                n_flag_byte = i_item.data_byte;
            end else if (r_byte_count == npfd_pkg::POS_TITLE) begin
                n_title_length = i_item.data_byte;
            end else if (r_byte_count == npfd_pkg::POS_ARTIST) begin
                n_artist_length = i_item.data_byte;
            end else if (r_byte_count == npfd_pkg::POS_ALBUM) begin
                n_album_length = i_item.data_byte;
            end else if (r_byte_count < npfd_pkg::POS_DURATION) begin
                n_elapsed_accum = npfd_pkg::put_lane(r_elapsed_accum,
                                                     r_byte_count[1:0], i_item.data_byte);
            end else begin
                n_duration_accum = npfd_pkg::put_lane(r_duration_accum,
                                                      r_byte_count[1:0], i_item.data_byte);
            end
        end else if (i_item.data_byte == 8'd0) begin
            n_zero_seen = 1'b1;
        end
        n_byte_count = sat ? r_byte_count : r_byte_count + 9'd1;
    end

    // Checks see the state including this byte
    assign frame_size  = {1'b0, r_byte_count} + 10'd1;
    assign expect_size = {1'b0, npfd_pkg::HEADER_LEN} + {2'b00, n_title_length}
                       + {2'b00, n_artist_length} + {2'b00, n_album_length};

    always_comb begin
        if (!sat && (frame_size < {1'b0, npfd_pkg::HEADER_LEN})) begin
            st = npfd_pkg::ST_SHORT;
        end else if (n_flag_byte > npfd_pkg::FLAG_MAX) begin
            st = npfd_pkg::ST_BAD_FLAGS;
        end else if ((n_title_length > npfd_pkg::MAX_TEXT_LEN)
                  || (n_artist_length > npfd_pkg::MAX_TEXT_LEN)
                  || (n_album_length > npfd_pkg::MAX_TEXT_LEN)) begin
            st = npfd_pkg::ST_LEN_LIMIT;
        end else if (sat || (frame_size != expect_size)) begin
            st = npfd_pkg::ST_SIZE;
        end else if (n_zero_seen) begin
            st = npfd_pkg::ST_ZERO_TEXT;
        end else begin
            st = npfd_pkg::ST_OK;
        end
    end

    always_comb begin
        o_result = '0;
        if (!in_header) begin
            if (sat) begin
                o_result.segment = npfd_pkg::SEG_EXCESS;
            end else if (q < e1) begin
                o_result.segment     = npfd_pkg::SEG_TITLE;
                o_result.text_offset = q[7:0];
            end else if (q < e2) begin
                o_result.segment     = npfd_pkg::SEG_ARTIST;
                o_result.text_offset = 8'(q - e1);
            end else if (q < e3) begin
                o_result.segment     = npfd_pkg::SEG_ALBUM;
                o_result.text_offset = 8'(q - e2);
            end else begin
                o_result.segment = npfd_pkg::SEG_EXCESS;
            end
            if ((o_result.segment != npfd_pkg::SEG_EXCESS)) begin
                o_result.text_char = i_item.data_byte;
            end
        end
        if (i_item.last_byte) begin
            o_result.frame_done = 1'b1;
            o_result.status     = st;
            if (st == npfd_pkg::ST_OK) begin
                o_result.connected        = n_flag_byte[0];
                o_result.ready_res        = n_flag_byte[1];
                o_result.playing          = n_flag_byte[2];
                o_result.elapsed_seconds  = n_elapsed_accum;
                o_result.duration_seconds = n_duration_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_byte_count     <= '0;
            r_flag_byte      <= '0;
            r_title_length   <= '0;
            r_artist_length  <= '0;
            r_album_length   <= '0;
            r_elapsed_accum  <= '0;
            r_duration_accum <= '0;
            r_zero_seen      <= 1'b0;
        end else if (i_fire) begin
            r_byte_count     <= n_byte_count;
            r_flag_byte      <= n_flag_byte;
            r_title_length   <= n_title_length;
            r_artist_length  <= n_artist_length;
            r_album_length   <= n_album_length;
            r_elapsed_accum  <= n_elapsed_accum;
            r_duration_accum <= n_duration_accum;
            r_zero_seen      <= n_zero_seen;
        end
    end

endmodule

### hw/rtl/now_playing_frame_decoder_top.sv
// The result is registered: it is valid in the output register in the cycle after the input transfer.
// Throughput: one byte per cycle; the parser state updates once per transfer.
// A held result stalls input only while the output register is full and not taken.
// Reset (synchronous, active low) clears the byte counter, header fields and
// the output valid; the first byte after reset starts a new frame.
`timescale 1ns / 1ps

module now_playing_frame_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  npfd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output npfd_pkg::t_out_item  o_out_data
);

    logic                r_out_valid;
    npfd_pkg::t_out_item r_out_data;
    npfd_pkg::t_out_item result;
    logic                in_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    npfd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result on every input transfer
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= result;
        end
    end

    a_done_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_out_valid && (r_out_data.frame_done == $past(i_in_data.last_byte))))
        else $error("frame_done does not follow last_byte");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.frame_done) |-> (r_out_data.status == npfd_pkg::ST_OK))
        else $error("status set on a byte that is not the last");

    a_fields_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_data.status != npfd_pkg::ST_OK))
        |-> (!r_out_data.connected && !r_out_data.ready_res && !r_out_data.playing
             && (r_out_data.elapsed_seconds == 32'd0)
             && (r_out_data.duration_seconds == 32'd0)))
        else $error("header fields reported on a failed frame");

    a_char_only_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out_data.segment == npfd_pkg::SEG_HEADER)
                      || (r_out_data.segment == npfd_pkg::SEG_EXCESS)))
        |-> ((r_out_data.text_char == 8'd0) && (r_out_data.text_offset == 8'd0)))
        else $error("text char or offset outside a text segment");

endmodule
